// ----- hw/rtl/brf_pkg.sv -----
// Shared definitions for the bitmap rectangle fill core.
// Holds the request field layout, operation codes and configuration reset value.
// No dependencies.
package brf_pkg;

  localparam int unsigned CFG_W        = 4;
  localparam int unsigned ROW_IN_W     = 6;
  localparam int unsigned ROWEND_IN_W  = 7;
  localparam int unsigned COL_IN_W     = 7;
  localparam int unsigned COLEND_IN_W  = 8;
  localparam int unsigned RDROW_W      = 6;
  localparam int unsigned RDWORD_W     = 3;
  localparam int unsigned ITEM_W       = ROW_IN_W + ROWEND_IN_W + COL_IN_W + COLEND_IN_W
                                         + RDROW_W + RDWORD_W;
  localparam int unsigned S_TDATA_W    = ((ITEM_W + 7) / 8) * 8;
  localparam int unsigned S_TUSER_W    = 1;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic [S_TUSER_W-1:0] OP_FILL = 1'b0;
  localparam logic [S_TUSER_W-1:0] OP_READ = 1'b1;

  // Packed so that row_begin lands in the lowest bits of tdata.
  typedef struct packed {
    logic [RDWORD_W-1:0]    read_word;
    logic [RDROW_W-1:0]     read_row;
    logic [COLEND_IN_W-1:0] col_end;
    logic [COL_IN_W-1:0]    col_begin;
    logic [ROWEND_IN_W-1:0] row_end;
    logic [ROW_IN_W-1:0]    row_begin;
  } item_t;

endpackage

// ----- hw/rtl/bitmap_rectangle_fill_core.sv -----
// Top level of the bitmap rectangle fill core: control sequencer around the word store.
// Depends on brf_pkg and brf_ram.
//
// Channel   Direction  Content
// s_axis    in         request: tuser = operation, tdata = rectangle and read address
// m_axis    out        result: tdata = read_data (zero for a fill)
// cfg       in         row_words, written when cfg_we_i is high
//
// After reset a clearing pass writes zeros to all MAX_ROWS*MAX_ROW_WORDS words, one a
// cycle, with s_axis_tready low.
// A fill runs a setup state, then one read-modify-write per word touched (rows times
// the words each row of the rectangle spans) on the single path through the store.
// A read runs setup, the store read and its wait state, then the done state.
// A new request is taken while an earlier result still waits on m_axis; a request
// finishing while m_axis stays stalled holds until the result register frees up.
module bitmap_rectangle_fill_core #(
  parameter int unsigned WORD_BITS     = 16,
  parameter int unsigned MAX_ROWS      = 64,
  parameter int unsigned MAX_ROW_WORDS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brf_pkg::CFG_W-1:0]           cfg_wdata_i,   // row_words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row_begin[5:0], row_end[12:6], col_begin[19:13], col_end[27:20],
  // read_row[33:28], read_word[36:34], zero padding above
  input  logic [brf_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  input  logic [brf_pkg::S_TUSER_W-1:0]       s_axis_tuser,  // operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]      m_axis_tdata   // read_data, zero padding above
);

  import brf_pkg::*;

  localparam int unsigned DEPTH   = MAX_ROWS * MAX_ROW_WORDS;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RWU_RAW = $clog2(MAX_ROW_WORDS + 1);
  localparam int unsigned RWU_W   = (RWU_RAW > CFG_W) ? RWU_RAW : CFG_W;
  localparam int unsigned ROW_RAW = $clog2(MAX_ROWS + 1);
  localparam int unsigned ROWC_W  = (ROW_RAW > ROWEND_IN_W) ? ROW_RAW : ROWEND_IN_W;
  localparam int unsigned COL_RAW = $clog2((MAX_ROW_WORDS + 1) * WORD_BITS + 1);
  localparam int unsigned COL_W   = (COL_RAW > COLEND_IN_W) ? COL_RAW : COLEND_IN_W;
  localparam int unsigned PROD_W  = ((AW > ROWC_W + RWU_W) ? AW : ROWC_W + RWU_W) + 1;
  localparam int unsigned BW_W    = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
  localparam int unsigned M_TDATA_W = ((WORD_BITS + 7) / 8) * 8;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_RDW   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]           st_q, st_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [AW-1:0]        clr_q;
  item_t                item_q;
  logic [S_TUSER_W-1:0] op_q;
  logic [ROWC_W-1:0]    re_q, row_q;
  logic [COL_W-1:0]     cb_q, ce_q, base_q, base0_q;
  logic [AW-1:0]        addr_q, rowbw_q;
  logic                 rd_ok_q;
  logic                 wr_v_q;
  logic [AW-1:0]        wr_addr_q;
  logic [WORD_BITS-1:0] wr_mask_q;
  logic [WORD_BITS-1:0] res_q;
  logic                 m_valid_q;
  logic [WORD_BITS-1:0] m_data_q;

  logic                 req_acc;
  logic                 out_free;
  logic [RWU_W-1:0]     rw_use;
  logic [COL_W-1:0]     col_limit, cb_w, ce_in, ce_clip;
  logic [ROWC_W-1:0]    re_in, re_clip;
  logic                 empty;
  logic [BW_W-1:0]      bw;
  logic [COL_W-1:0]     base0;
  logic [PROD_W-1:0]    row_start, rd_prod, rowbw_sum;
  logic                 rd_ok;
  logic [WORD_BITS-1:0] mask;
  logic [COL_W-1:0]     base_next;
  logic                 last_word, last_row;
  logic [AW-1:0]        rowbw_next;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Row width in use: zero acts as one, anything above the maximum is clamped.
  always_comb begin
    if (cfg_q == '0) begin
      rw_use = RWU_W'(1);
    end else if (RWU_W'(cfg_q) > RWU_W'(MAX_ROW_WORDS)) begin
      rw_use = RWU_W'(MAX_ROW_WORDS);
    end else begin
      rw_use = RWU_W'(cfg_q);
    end
  end

  assign col_limit = COL_W'(rw_use) * COL_W'(WORD_BITS);
  assign cb_w      = COL_W'(item_q.col_begin);
  assign ce_in     = COL_W'(item_q.col_end);
  assign ce_clip   = (ce_in > col_limit) ? col_limit : ce_in;
  assign re_in     = ROWC_W'(item_q.row_end);
  assign re_clip   = (re_in > ROWC_W'(MAX_ROWS)) ? ROWC_W'(MAX_ROWS) : re_in;
  assign empty     = (ROWC_W'(item_q.row_begin) >= re_clip) || (cb_w >= ce_clip);

  // First word of each row and its first column, found by comparing against each
  // word's column range.
  always_comb begin
    bw    = '0;
    base0 = '0;
    for (int k = 0; k < int'(MAX_ROW_WORDS); k++) begin
      if (cb_w >= COL_W'(k * WORD_BITS) && cb_w < COL_W'((k + 1) * WORD_BITS)) begin
        bw    = bw | BW_W'(k);
        base0 = base0 | COL_W'(k * WORD_BITS);
      end
    end
  end

  assign row_start = PROD_W'(item_q.row_begin) * PROD_W'(rw_use) + PROD_W'(bw);
  assign rd_prod   = PROD_W'(item_q.read_row) * PROD_W'(rw_use) + PROD_W'(item_q.read_word);
  assign rd_ok     = (ROWC_W'(item_q.read_row) < ROWC_W'(MAX_ROWS))
                     && (RWU_W'(item_q.read_word) < rw_use);

  // Per-pixel mask for the word whose first column is base_q.
  always_comb begin
    for (int j = 0; j < int'(WORD_BITS); j++) begin
      mask[j] = ((base_q + COL_W'(j)) >= cb_q) && ((base_q + COL_W'(j)) < ce_q);
    end
  end

  assign base_next  = base_q + COL_W'(WORD_BITS);
  assign last_word  = base_next >= ce_q;
  assign last_row   = (row_q + ROWC_W'(1)) >= re_q;
  assign rowbw_sum  = PROD_W'(rowbw_q) + PROD_W'(rw_use);
  assign rowbw_next = rowbw_sum[AW-1:0];

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          st_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (op_q == OP_READ) begin
          st_d = ST_RD;
        end else if (empty) begin
          st_d = ST_DONE;
        end else begin
          st_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (last_word && last_row) begin
          st_d = ST_DONE;
        end
      end
      ST_RD:   st_d = ST_RDW;
      ST_RDW:  st_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLR;
      cfg_q     <= CFG_RESET;
      clr_q     <= '0;
      wr_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wr_v_q <= (st_q == ST_FILL);
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (st_q == ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (st_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      item_q <= item_t'(s_axis_tdata[ITEM_W-1:0]);
      op_q   <= s_axis_tuser;
    end
    case (st_q)
      ST_SETUP: begin
        re_q    <= re_clip;
        cb_q    <= cb_w;
        ce_q    <= ce_clip;
        row_q   <= ROWC_W'(item_q.row_begin);
        base_q  <= base0;
        base0_q <= base0;
        rowbw_q <= row_start[AW-1:0];
        rd_ok_q <= rd_ok;
        res_q   <= '0;
        if (op_q == OP_READ) begin
          addr_q <= rd_prod[AW-1:0];
        end else begin
          addr_q <= row_start[AW-1:0];
        end
      end
      ST_FILL: begin
        wr_addr_q <= addr_q;
        wr_mask_q <= mask;
        if (!last_word) begin
          addr_q <= addr_q + AW'(1);
          base_q <= base_next;
        end else begin
          row_q   <= row_q + ROWC_W'(1);
          rowbw_q <= rowbw_next;
          addr_q  <= rowbw_next;
          base_q  <= base0_q;
        end
      end
      ST_RDW: begin
        res_q <= rd_ok_q ? mem_rdata : '0;
      end
      default: begin
      end
    endcase
    if (st_q == ST_DONE && out_free) begin
      m_data_q <= res_q;
    end
  end

  // The write of a fill word comes in the cycle after its read and merges the mask into the read data.
  assign mem_we    = (st_q == ST_CLR) || wr_v_q;
  assign mem_waddr = (st_q == ST_CLR) ? clr_q : wr_addr_q;
  assign mem_wdata = (st_q == ST_CLR) ? '0 : (mem_rdata | wr_mask_q);

  brf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (WORD_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_data_q);

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLR) |-> !s_axis_tready)
    else $error("request taken during the clearing pass");

  a_write_follows_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> ($past(st_q) == ST_FILL))
    else $error("bitmap write without a preceding fill read");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> (wr_addr_q != addr_q))
    else $error("read and write of the same word in one cycle");

  a_fill_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FILL) |-> ((AW + 1)'(addr_q) < (AW + 1)'(DEPTH)))
    else $error("fill address beyond the bitmap");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(st_q) == ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule

// ----- hw/rtl/brf_ram.sv -----
// Bitmap word store: one write port and one read port with registered read data.
// No package dependencies.
module brf_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/sv/bitmap_fill_checker.sv -----
// Checker for the bitmap rectangle fill core: mirrors the pixel store, predicts each result
// and compares it with what leaves the master side. Depends on brf_pkg.
module bitmap_fill_checker #(
  parameter int unsigned WORD_BITS     = 16,
  parameter int unsigned MAX_ROWS      = 64,
  parameter int unsigned MAX_ROW_WORDS = 8,
  parameter int unsigned M_TDATA_W     = ((WORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brf_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  input  logic [brf_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic [brf_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  input  logic [M_TDATA_W-1:0]            m_axis_tdata_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     error_count_o
);

  import brf_pkg::*;

  localparam int unsigned STORE_WORDS = MAX_ROWS * MAX_ROW_WORDS;

  logic [WORD_BITS-1:0] pixel_words [STORE_WORDS];
  logic [CFG_W-1:0]     row_words_q;
  logic [WORD_BITS-1:0] expected_words [$];
  item_t                req_item;
  logic [WORD_BITS-1:0] want_word;
  int unsigned          mismatches = 0;

  assign error_count_o = mismatches;

  // Out-of-range register values are folded into the legal width range.
  function automatic int unsigned words_in_use();
    if (row_words_q == '0) return 1;
    if (32'(row_words_q) > MAX_ROW_WORDS) return MAX_ROW_WORDS;
    return 32'(row_words_q);
  endfunction

  function automatic void paint_rectangle(item_t req);
    int unsigned width, col_limit, rb, re, cb, ce, first_w, last_w;
    logic [WORD_BITS-1:0] head_mask, tail_mask, mask;
    width     = words_in_use();
    col_limit = width * WORD_BITS;
    rb = 32'(req.row_begin);
    re = 32'(req.row_end);
    cb = 32'(req.col_begin);
    ce = 32'(req.col_end);
    if (re > MAX_ROWS) re = MAX_ROWS;
    if (ce > col_limit) ce = col_limit;
    if (rb >= re || cb >= ce) return;
    first_w   = cb / WORD_BITS;
    last_w    = ce / WORD_BITS;
    head_mask = {WORD_BITS{1'b1}} << (cb % WORD_BITS);
    // A column end on a word boundary yields an empty tail mask.
    tail_mask = ~({WORD_BITS{1'b1}} << (ce % WORD_BITS));
    for (int unsigned r = rb; r < re; r++) begin
      for (int unsigned w = first_w; w <= last_w && w < width; w++) begin
        mask = '1;
        if (w == first_w) mask &= head_mask;
        if (w == last_w) mask &= tail_mask;
        pixel_words[(r * width + w) % STORE_WORDS] |= mask;
      end
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] fetch_word(item_t req);
    int unsigned width, row, word;
    width = words_in_use();
    row   = 32'(req.read_row);
    word  = 32'(req.read_word);
    if (row >= MAX_ROWS || word >= width) return '0;
    return pixel_words[(row * width + word) % STORE_WORDS];
  endfunction

  task automatic report_mismatch(input string what, input logic [M_TDATA_W-1:0] got,
                                 input logic [M_TDATA_W-1:0] want);
    mismatches++;
    $display("%0t: read_data mismatch (%s): got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pixel_words[i]) pixel_words[i] = '0;
      row_words_q = CFG_RESET;
      expected_words.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) row_words_q = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        req_item = item_t'(s_axis_tdata_i[ITEM_W-1:0]);
        if (s_axis_tuser_i == OP_FILL) begin
          paint_rectangle(req_item);
          expected_words.push_back('0);
        end else begin
          expected_words.push_back(fetch_word(req_item));
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("no request outstanding", m_axis_tdata_i, '0);
        end else begin
          want_word = expected_words.pop_front();
          if (m_axis_tdata_i !== M_TDATA_W'(want_word))
            report_mismatch("wrong word", m_axis_tdata_i, M_TDATA_W'(want_word));
        end
      end
      outstanding_o <= expected_words.size();
    end
  end

endmodule

// ----- tb/sv/tb_bitmap_rectangle_fill_core.sv -----
// Testbench top for the bitmap rectangle fill core: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on brf_pkg, bitmap_rectangle_fill_core and bitmap_fill_checker.
module tb_bitmap_rectangle_fill_core;
  import brf_pkg::*;

  localparam int unsigned WORD_BITS     = 16;
  localparam int unsigned MAX_ROWS      = 64;
  localparam int unsigned MAX_ROW_WORDS = 8;
  localparam int unsigned M_TDATA_W     = ((WORD_BITS + 7) / 8) * 8;
  // Covers the clearing pass and a whole-bitmap fill many times over.
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned BLOCK_ITEMS   = 320;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = OP_FILL;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned width_words   = 8;
  int unsigned stall_cycles  = 0;
  int unsigned outstanding;
  int unsigned error_count;

  bitmap_rectangle_fill_core #(
    .WORD_BITS    (WORD_BITS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_ROW_WORDS(MAX_ROW_WORDS)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bitmap_fill_checker #(
    .WORD_BITS    (WORD_BITS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_ROW_WORDS(MAX_ROW_WORDS),
    .M_TDATA_W    (M_TDATA_W)
  ) fill_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .outstanding_o  (outstanding),
    .error_count_o  (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Holds the request until it is taken; valid stays high into the next request
  // unless that one starts with an idle gap.
  task automatic push_request(input logic [S_TUSER_W-1:0] op, input item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(req);
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_row_words(input logic [CFG_W-1:0] value);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk);
    cfg_we_i    <= 1'b0;
    width_words = (value == '0) ? 1 :
                  (32'(value) > MAX_ROW_WORDS) ? MAX_ROW_WORDS : 32'(value);
  endtask

  task automatic send_fill(input int unsigned rb, input int unsigned re,
                           input int unsigned cb, input int unsigned ce);
    item_t req;
    req.row_begin = ROW_IN_W'(rb);
    req.row_end   = ROWEND_IN_W'(re);
    req.col_begin = COL_IN_W'(cb);
    req.col_end   = COLEND_IN_W'(ce);
    req.read_row  = RDROW_W'($urandom_range(63));
    req.read_word = RDWORD_W'($urandom_range(7));
    push_request(OP_FILL, req);
  endtask

  task automatic send_read(input int unsigned row, input int unsigned word);
    item_t req;
    req.row_begin = ROW_IN_W'($urandom_range(63));
    req.row_end   = ROWEND_IN_W'($urandom_range(127));
    req.col_begin = COL_IN_W'($urandom_range(127));
    req.col_end   = COLEND_IN_W'($urandom_range(255));
    req.read_row  = RDROW_W'(row);
    req.read_word = RDWORD_W'(word);
    push_request(OP_READ, req);
  endtask

  // Fills are kept mostly narrow so the bitmap does not saturate and stays cheap;
  // a few take random column ranges or fully random corners.
  task automatic send_random_request();
    int unsigned pick, rb, cb;
    pick = $urandom_range(99);
    if (pick >= 38) begin
      send_read($urandom_range(63), $urandom_range(7));
    end else begin
      rb = $urandom_range(63);
      cb = $urandom_range(width_words * WORD_BITS - 1);
      if (pick < 1) begin
        send_fill(rb, $urandom_range(127), $urandom_range(127), $urandom_range(255));
      end else if (pick < 5) begin
        send_fill(rb, rb + $urandom_range(1, 2), $urandom_range(127), $urandom_range(255));
      end else begin
        send_fill(rb, rb + $urandom_range(1, 2), cb, cb + $urandom_range(1, 12));
      end
    end
  endtask

  task automatic run_block(input logic [CFG_W-1:0] value, input int unsigned send_pct,
                           input int unsigned recv_pct);
    write_row_words(value);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (BLOCK_ITEMS) begin
      send_random_request();
      if ($urandom_range(149) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 16;
    recv_idle_pct = 59;

    write_row_words(4'd8);
    send_read(0, 0);
    send_fill(0, 0, 0, 0);
    // Rectangle inside a single word.
    send_fill(2, 3, 3, 9);
    send_read(2, 0);
    // Column end on a word boundary leaves the following word untouched.
    send_fill(4, 5, 5, 32);
    send_read(4, 0);
    send_read(4, 1);
    send_read(4, 2);
    send_fill(6, 8, 20, 100);
    send_read(7, 1);
    send_read(7, 6);
    // Empty rectangles: equal rows, reversed rows, equal columns.
    send_fill(10, 10, 0, 128);
    send_fill(12, 11, 0, 128);
    send_fill(13, 14, 50, 50);
    send_read(10, 0);
    send_read(12, 3);
    send_read(13, 3);
    // Both ends past the bitmap are clipped.
    send_fill(63, 127, 127, 255);
    send_read(63, 7);

    // Narrower rows reinterpret the stored words; reads past the row width give zero.
    write_row_words(4'd3);
    send_read(5, 1);
    send_read(1, 5);
    send_read(63, 7);
    send_fill(0, 2, 40, 255);
    send_read(1, 2);

    run_block(4'd15, 16, 59);
    run_block(4'd0, 16, 59);
    run_block(4'd1, 59, 16);
    run_block(4'd5, 59, 16);
    run_block(4'd10, 0, 0);
    run_block(4'd8, 0, 0);

    send_fill(0, 64, 0, 128);
    send_read(0, 0);
    send_read(31, 4);
    send_read(63, 7);

    drain_results();
    repeat (32) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/brf_pkg.sv
hw/rtl/brf_ram.sv
hw/rtl/bitmap_rectangle_fill_core.sv
tb/sv/bitmap_fill_checker.sv
tb/sv/tb_bitmap_rectangle_fill_core.sv
